FILE: src/ffba_pkg.sv
`timescale 1ns / 1ps
// ffba_pkg: shared types, status codes, register indexes and default sizes
// for the first-fit block allocator; no dependencies
package ffba_pkg;

    localparam int DEF_MAX_BLOCKS   = 64;
    localparam int DEF_HEADER_BYTES = 32;

    localparam int OFF_W   = 24;
    localparam int ADDR_W  = 32;
    localparam int STAT_W  = 2;

    typedef logic [STAT_W-1:0] t_status;
    localparam t_status ST_OK      = 2'd0;
    localparam t_status ST_NULL    = 2'd1;
    localparam t_status ST_NOSPACE = 2'd2;
    localparam t_status ST_UNKNOWN = 2'd3;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic REG_HEAP_BASE  = 1'b0;
    localparam logic REG_HEAP_LIMIT = 1'b1;

    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [OFF_W-1:0] size;
        logic             free;
    } t_entry;

endpackage

FILE: src/ffba_table.sv
`timescale 1ns / 1ps
// ffba_table: block table memory, one write port and one registered read port
// depends on ffba_pkg for the entry type
module ffba_table #(
    parameter int DEPTH = ffba_pkg::DEF_MAX_BLOCKS,
    parameter int IW    = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [IW-1:0]     i_rd_addr,
    output ffba_pkg::t_entry  o_rd_data,
    input  logic              i_wr_en,
    input  logic [IW-1:0]     i_wr_addr,
    input  ffba_pkg::t_entry  i_wr_data
);

    ffba_pkg::t_entry r_mem [DEPTH];
    ffba_pkg::t_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/first_fit_block_allocator_top.sv
`timescale 1ns / 1ps
// first_fit_block_allocator_top: first-fit heap allocator with a walked block table
// depends on ffba_pkg and ffba_table
//
// Each item is an allocate or a free and gives exactly one result item. The block
// takes one item at a time: after an item is accepted, the sequencer walks the block
// table from entry 0, reading one entry per cycle from the table memory's registered
// read port, and stops at the first fit (allocate) or the first address match (free).
// A zero-size allocate or a null free skips the walk. The next item is taken in the
// cycle after the result is registered. A finished result sits in an output
// register, so the next item is accepted while it waits to be taken; a result that
// finds the output register still occupied holds the sequencer until the earlier one
// is taken.
module first_fit_block_allocator_top #(
    parameter int MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // req_size[23:0], free_addr[55:24]
    input  logic        i_s_tuser,   // op[0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // status[1:0], payload_addr[33:2], zero[39:34]
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);
    localparam logic [25:0] HDR26 = 26'(HEADER_BYTES);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_BLOCKS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_HIT,
        S_MISS,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [31:0]       r_heap_base;
    logic [23:0]       r_heap_limit;
    logic [CW-1:0]     r_count;
    logic [23:0]       r_top;
    logic              r_op;
    logic [23:0]       r_size;
    logic [31:0]       r_target;
    logic [CW-1:0]     r_issued;
    logic              r_chk_valid;
    logic [IW-1:0]     r_chk_idx;
    logic [IW-1:0]     r_hit_idx;
    ffba_pkg::t_entry  r_hit_data;
    ffba_pkg::t_status r_res_status;
    logic [31:0]       r_res_addr;
    logic              r_out_valid;
    ffba_pkg::t_status r_out_status;
    logic [31:0]       r_out_addr;

    ffba_pkg::t_entry  rd_data;
    logic              rd_en;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    ffba_pkg::t_entry  wr_data;
    logic              hit;
    logic [25:0]       n_need;
    logic              hit_is_last;

    ffba_table #(
        .DEPTH (MAX_BLOCKS),
        .IW    (IW)
    ) u_table (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_issued[IW-1:0]),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // shared compare unit: fit test on allocate, address match on free
    always_comb begin
        if (r_op == ffba_pkg::OP_ALLOC) begin
            hit = rd_data.free && (rd_data.size >= r_size);
        end else begin
            hit = ({8'd0, rd_data.start} == r_target);
        end
    end

    assign rd_en       = (r_state == S_SCAN) && (r_issued < r_count);
    assign n_need      = {2'd0, r_top} + HDR26 + {2'd0, r_size};
    assign hit_is_last = ((CW'(r_hit_idx) + CW'(1)) == r_count);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_hit_idx;
        wr_data = r_hit_data;
        case (r_state)
            S_HIT: begin
                if (r_op == ffba_pkg::OP_ALLOC) begin
                    wr_en        = 1'b1;
                    wr_data.free = 1'b0;
                end else if (!hit_is_last) begin
                    wr_en        = 1'b1;
                    wr_data.free = 1'b1;
                end
            end
            S_MISS: begin
                wr_addr       = r_count[IW-1:0];
                wr_data.start = r_top;
                wr_data.size  = r_size;
                wr_data.free  = 1'b0;
                wr_en = (r_op == ffba_pkg::OP_ALLOC) && (r_count != CNT_MAX)
                        && (n_need <= {2'd0, r_heap_limit});
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_heap_base  <= '0;
            r_heap_limit <= 24'hFFFFFF;
            r_count      <= '0;
            r_top        <= '0;
            r_issued     <= '0;
            r_chk_valid  <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ffba_pkg::REG_HEAP_BASE:  r_heap_base  <= i_cfg_wdata;
                    ffba_pkg::REG_HEAP_LIMIT: r_heap_limit <= i_cfg_wdata[23:0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_m_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_op         <= i_s_tuser;
                        r_size       <= i_s_tdata[23:0];
                        r_target     <= i_s_tdata[55:24] - r_heap_base - HDR32;
                        r_issued     <= '0;
                        r_chk_valid  <= 1'b0;
                        r_res_status <= ffba_pkg::ST_OK;
                        r_res_addr   <= '0;
                        if (i_s_tuser == ffba_pkg::OP_ALLOC && i_s_tdata[23:0] == 24'd0) begin
                            r_res_status <= ffba_pkg::ST_NULL;
                            r_state      <= S_DONE;
                        end else if (i_s_tuser == ffba_pkg::OP_FREE
                                     && i_s_tdata[55:24] == 32'd0) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    r_chk_valid <= rd_en;
                    r_chk_idx   <= r_issued[IW-1:0];
                    if (rd_en) begin
                        r_issued <= r_issued + CW'(1);
                    end
                    if (r_chk_valid && hit) begin
                        r_hit_idx  <= r_chk_idx;
                        r_hit_data <= rd_data;
                        r_state    <= S_HIT;
                    end else if (!r_chk_valid && !rd_en) begin
                        r_state <= S_MISS;
                    end
                end
                S_HIT: begin
                    if (r_op == ffba_pkg::OP_ALLOC) begin
                        r_res_addr <= r_heap_base + {8'd0, r_hit_data.start} + HDR32;
                    end else if (hit_is_last) begin
                        r_top   <= r_hit_data.start;
                        r_count <= r_count - CW'(1);
                    end
                    r_state <= S_DONE;
                end
                S_MISS: begin
                    if (r_op == ffba_pkg::OP_FREE) begin
                        r_res_status <= ffba_pkg::ST_UNKNOWN;
                    end else if (wr_en) begin
                        r_res_addr <= r_heap_base + {8'd0, r_top} + HDR32;
                        r_count    <= r_count + CW'(1);
                        r_top      <= n_need[23:0];
                    end else begin
                        r_res_status <= ffba_pkg::ST_NOSPACE;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || i_m_tready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_addr   <= r_res_addr;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {6'd0, r_out_addr, r_out_status};

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("block count above table depth");

    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_top == '0))
        else $error("heap top not zero with empty table");

    a_chk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk_valid |-> (CW'(r_chk_idx) < r_count))
        else $error("checked entry beyond block count");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready right after an accepted item");

    a_fail_null_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != ffba_pkg::ST_OK) |-> (r_out_addr == '0))
        else $error("nonzero payload address on a failed request");

endmodule

FILE: test/tb_first_fit_block_allocator_top.sv
`timescale 1ns / 1ps
// tb_first_fit_block_allocator_top: self-checking bench for the first-fit block allocator
// depends on ffba_pkg and first_fit_block_allocator_top; holds its own allocator predictor
module tb_first_fit_block_allocator_top;

    localparam int NBLK          = ffba_pkg::DEF_MAX_BLOCKS;
    localparam int HDR           = ffba_pkg::DEF_HEADER_BYTES;
    localparam int OFF_W         = ffba_pkg::OFF_W;
    localparam int ADDR_W        = ffba_pkg::ADDR_W;
    localparam int LIMIT_CYCLES  = 400000;
    localparam int SETTLE_CYCLES = NBLK + 16;
    localparam int PHASE_ITEMS   = 116;
    localparam int HOLD_CYCLES   = 400;

    typedef struct packed {
        ffba_pkg::t_status status;
        logic [ADDR_W-1:0] payload;
    } t_reply;

    class alloc_scoreboard;
        logic [ADDR_W-1:0] heap_base;
        logic [OFF_W-1:0]  heap_limit;
        logic [OFF_W-1:0]  blk_start [NBLK];
        logic [OFF_W-1:0]  blk_size [NBLK];
        bit                blk_free [NBLK];
        int                blk_count;
        logic [OFF_W-1:0]  heap_top;
        t_reply            pending_replies [$];
        int                errors;
        int                requests;
        int                replies;
        int                peak_count;
        int                status_seen [4];

        function new();
            heap_base  = '0;
            heap_limit = '1;
            blk_count  = 0;
            heap_top   = '0;
            errors     = 0;
            requests   = 0;
            replies    = 0;
            peak_count = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void write_reg(logic idx, logic [31:0] value);
            if (idx == ffba_pkg::REG_HEAP_BASE) begin
                heap_base = value;
            end else begin
                heap_limit = value[OFF_W-1:0];
            end
        endfunction

        function logic [ADDR_W-1:0] payload_at(int idx);
            return heap_base + {8'd0, blk_start[idx]} + ADDR_W'(HDR);
        endfunction

        function t_reply predict_alloc(logic [OFF_W-1:0] size);
            t_reply            r;
            logic [ADDR_W-1:0] need;
            r.status  = ffba_pkg::ST_OK;
            r.payload = '0;
            if (size == 0) begin
                r.status = ffba_pkg::ST_NULL;
                return r;
            end
            for (int i = 0; i < blk_count; i++) begin
                if (blk_free[i] && blk_size[i] >= size) begin
                    blk_free[i] = 1'b0;
                    r.payload   = payload_at(i);
                    return r;
                end
            end
            if (blk_count >= NBLK) begin
                r.status = ffba_pkg::ST_NOSPACE;
                return r;
            end
            need = {8'd0, heap_top} + ADDR_W'(HDR) + {8'd0, size};
            if (need > {8'd0, heap_limit}) begin
                r.status = ffba_pkg::ST_NOSPACE;
                return r;
            end
            blk_start[blk_count] = heap_top;
            blk_size[blk_count]  = size;
            blk_free[blk_count]  = 1'b0;
            r.payload            = payload_at(blk_count);
            blk_count++;
            heap_top = need[OFF_W-1:0];
            return r;
        endfunction

        function t_reply predict_free(logic [ADDR_W-1:0] addr);
            t_reply r;
            int     hit;
            r.status  = ffba_pkg::ST_OK;
            r.payload = '0;
            hit       = -1;
            if (addr == 0) return r;
            for (int i = 0; i < blk_count; i++) begin
                if (hit < 0 && payload_at(i) == addr) hit = i;
            end
            if (hit < 0) begin
                r.status = ffba_pkg::ST_UNKNOWN;
            end else if (hit == blk_count - 1) begin
                heap_top = blk_start[hit];
                blk_count--;
            end else begin
                blk_free[hit] = 1'b1;
            end
            return r;
        endfunction

        function void note_request(logic op, logic [OFF_W-1:0] size,
                                   logic [ADDR_W-1:0] addr);
            if (op == ffba_pkg::OP_ALLOC) begin
                pending_replies.push_back(predict_alloc(size));
            end else begin
                pending_replies.push_back(predict_free(addr));
            end
            requests++;
            if (blk_count > peak_count) peak_count = blk_count;
        endfunction

        task report(string what);
            errors++;
            $display("mismatch %0d: %s", errors, what);
        endtask

        task check_result(ffba_pkg::t_status status, logic [ADDR_W-1:0] payload);
            t_reply want;
            replies++;
            if (!$isunknown(status)) status_seen[status]++;
            if (pending_replies.size() == 0) begin
                report($sformatf("reply with none pending: status %0d payload %h",
                                 status, payload));
                return;
            end
            want = pending_replies.pop_front();
            if (status !== want.status) begin
                report($sformatf("reply %0d status %0d, predicted %0d",
                                 replies, status, want.status));
            end
            if (payload !== want.payload) begin
                report($sformatf("reply %0d payload %h, predicted %h",
                                 replies, payload, want.payload));
            end
        endtask

        task check_leftover();
            if (pending_replies.size() != 0) begin
                report($sformatf("%0d replies never arrived", pending_replies.size()));
            end
        endtask
    endclass

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_wdata = '0;
    logic        s_tvalid  = 1'b0;
    logic [55:0] s_tdata   = '0;
    logic        s_tuser   = 1'b0;
    logic        m_tready  = 1'b0;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;

    int s_idle_pct   = 0;
    int r_stall_pct  = 0;
    int hold_request = 0;
    int hold_left    = 0;
    int cycles       = 0;

    alloc_scoreboard sb = new();

    first_fit_block_allocator_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),   // req_size[23:0], free_addr[55:24]
        .i_s_tuser   (s_tuser),   // op[0]
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata)    // status[1:0], payload_addr[33:2], zero[39:34]
    );

    always #2 clk = ~clk;

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // receiver side: random stalls plus one long hold-off
    initial begin
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= r_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata[1:0], m_tdata[33:2]);
    end

    task automatic set_mode(int mode);
        case (mode)
            0: begin s_idle_pct = 0;  r_stall_pct = 0;  end
            1: begin s_idle_pct = 48; r_stall_pct = 0;  end
            2: begin s_idle_pct = 0;  r_stall_pct = 48; end
            default: begin s_idle_pct = 9; r_stall_pct = 9; end
        endcase
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    task automatic send_item(logic op, logic [OFF_W-1:0] size, logic [ADDR_W-1:0] addr);
        @(negedge clk);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {addr, size};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(op, size, addr);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (sb.pending_replies.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly live addresses and small sizes, with some noise and near misses
    task automatic run_random(int count, int alloc_pct);
        logic              op;
        logic [OFF_W-1:0]  size;
        logic [ADDR_W-1:0] addr;
        int                sel;
        repeat (count) begin
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 99) < alloc_pct) begin
                op   = ffba_pkg::OP_ALLOC;
                addr = $urandom;
                if (sel < 3)       size = '0;
                else if (sel < 8)  size = OFF_W'($urandom);
                else if (sel < 20) size = OFF_W'($urandom_range(1, 65535));
                else               size = OFF_W'($urandom_range(1, 512));
            end else begin
                op   = ffba_pkg::OP_FREE;
                size = OFF_W'($urandom);
                if (sel < 4) begin
                    addr = '0;
                end else if (sel < 10 || sb.blk_count == 0) begin
                    addr = $urandom;
                end else if (sel < 16) begin
                    addr = sb.payload_at($urandom_range(0, sb.blk_count - 1))
                           + $urandom_range(1, 3);
                end else begin
                    addr = sb.payload_at($urandom_range(0, sb.blk_count - 1));
                end
            end
            send_item(op, size, addr);
        end
    endtask

    initial begin
        logic [ADDR_W-1:0] popped_addr;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_mode(0);
        write_reg(ffba_pkg::REG_HEAP_BASE, 32'h0000_1000);
        write_reg(ffba_pkg::REG_HEAP_LIMIT, 32'h00FF_FFFF);

        send_item(ffba_pkg::OP_ALLOC, '0, '1);
        send_item(ffba_pkg::OP_ALLOC, '1, '0);
        send_item(ffba_pkg::OP_ALLOC, 24'd100, '0);
        send_item(ffba_pkg::OP_ALLOC, 24'd200, '0);
        send_item(ffba_pkg::OP_ALLOC, 24'd50, '0);
        send_item(ffba_pkg::OP_FREE, '1, '0);
        send_item(ffba_pkg::OP_FREE, '0, sb.payload_at(0) + 1);
        send_item(ffba_pkg::OP_FREE, '0, sb.payload_at(1));
        send_item(ffba_pkg::OP_FREE, '0, sb.payload_at(1));
        send_item(ffba_pkg::OP_ALLOC, 24'd150, '0);
        send_item(ffba_pkg::OP_ALLOC, 24'd300, '0);
        popped_addr = sb.payload_at(3);
        send_item(ffba_pkg::OP_FREE, '0, popped_addr);
        send_item(ffba_pkg::OP_FREE, '0, popped_addr);
        // exact fit up to the heap limit, then one byte more
        send_item(ffba_pkg::OP_ALLOC, OFF_W'(24'hFF_FFFF - sb.heap_top - HDR), '0);
        send_item(ffba_pkg::OP_ALLOC, 24'd1, '0);
        send_item(ffba_pkg::OP_FREE, '0, sb.payload_at(sb.blk_count - 1));
        send_item(ffba_pkg::OP_FREE, '0, '1);
        send_item(ffba_pkg::OP_ALLOC, 24'd1, '1);
        wait_idle();

        // fill the table with wrapping addresses
        write_reg(ffba_pkg::REG_HEAP_BASE, 32'hFFFF_FFF0);
        set_mode(0);
        run_random(PHASE_ITEMS, 90);
        wait_idle();

        write_reg(ffba_pkg::REG_HEAP_BASE, 32'hFFFF_FFFF);
        set_mode(1);
        run_random(PHASE_ITEMS, 35);
        wait_idle();

        // limit dropped under the current top, with a long receiver hold-off
        write_reg(ffba_pkg::REG_HEAP_BASE, $urandom);
        write_reg(ffba_pkg::REG_HEAP_LIMIT, {8'd0, sb.heap_top >> 1});
        set_mode(2);
        hold_request = HOLD_CYCLES;
        run_random(PHASE_ITEMS, 60);
        wait_idle();

        write_reg(ffba_pkg::REG_HEAP_BASE, 32'h0000_0000);
        write_reg(ffba_pkg::REG_HEAP_LIMIT, 32'h0000_0000);
        set_mode(3);
        run_random(PHASE_ITEMS, 50);
        wait_idle();

        write_reg(ffba_pkg::REG_HEAP_BASE, $urandom);
        write_reg(ffba_pkg::REG_HEAP_LIMIT, 32'd4096);
        set_mode(0);
        run_random(PHASE_ITEMS, 65);
        wait_idle();

        write_reg(ffba_pkg::REG_HEAP_BASE, $urandom);
        write_reg(ffba_pkg::REG_HEAP_LIMIT, 32'h00FF_FFFF);
        set_mode(1);
        run_random(PHASE_ITEMS, 55);
        wait_idle();

        write_reg(ffba_pkg::REG_HEAP_BASE, 32'h8000_0000);
        write_reg(ffba_pkg::REG_HEAP_LIMIT, {8'd0, 24'($urandom)});
        set_mode(2);
        run_random(PHASE_ITEMS, 50);
        wait_idle();

        write_reg(ffba_pkg::REG_HEAP_BASE, $urandom);
        write_reg(ffba_pkg::REG_HEAP_LIMIT, 32'h00FF_FFFF);
        set_mode(3);
        run_random(PHASE_ITEMS, 70);
        wait_idle();

        sb.check_leftover();
        $display("%0d requests and %0d replies: ok %0d, null %0d, no space %0d, unknown %0d",
                 sb.requests, sb.replies, sb.status_seen[ffba_pkg::ST_OK],
                 sb.status_seen[ffba_pkg::ST_NULL], sb.status_seen[ffba_pkg::ST_NOSPACE],
                 sb.status_seen[ffba_pkg::ST_UNKNOWN]);
        $display("table peaked at %0d of %0d entries across nine register settings",
                 sb.peak_count, NBLK);
        if (sb.errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
